// ----- hw/rtl/mbc1_pkg.sv -----
package mbc1_pkg;

    // Field widths
    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_ADDR_W = 19;
    localparam int RAM_ADDR_W = 15;

    // Cartridge geometry
    localparam int ROM_BANKS      = 32;
    localparam int BANK_BYTES     = 16384;
    localparam int BANK_AW        = $clog2(BANK_BYTES);
    localparam int ROM_BANK_W     = ROM_ADDR_W - BANK_AW;
    localparam int ROM_SEL_W      = 7;
    localparam int RAM_SEL_W      = 2;
    localparam int RAM_BANK_AW    = RAM_ADDR_W - RAM_SEL_W;
    localparam int RAM_DEPTH      = 1 << RAM_ADDR_W;
    localparam int ROM_DEPTH      = 1 << ROM_ADDR_W;
    localparam int CLR_CNT_W      = RAM_ADDR_W + 1;
    localparam int ROM_SEL_VALUES = 1 << ROM_SEL_W;

    // Register write masks and reset values
    localparam logic [DATA_W-1:0]    ROM_LOW_MASK  = 8'h1F;
    localparam logic [ROM_SEL_W-1:0] ROM_SEL_RESET = 7'd1;

    // Address region codes, taken from addr[15:13]
    localparam logic [2:0] REGION_RAM_EN   = 3'b000;
    localparam logic [2:0] REGION_ROM_LOW  = 3'b001;
    localparam logic [2:0] REGION_BANK_HI  = 3'b010;
    localparam logic [2:0] REGION_MODE     = 3'b011;
    localparam logic [2:0] REGION_EXT_RAM  = 3'b101;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_LOAD  = 2'd2
    } func_t;

    // Where the pending read word comes from
    typedef enum logic [1:0] {
        SRC_ROM     = 2'd0,
        SRC_RAM     = 2'd1,
        SRC_INVALID = 2'd2
    } src_t;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [ROM_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]     wdata;
    } rom_req_t;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [RAM_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]     wdata;
    } ram_req_t;

    // Bank register modulo the bank count, as a constant lookup
    function automatic logic [ROM_BANK_W-1:0] bank_wrap(input logic [ROM_SEL_W-1:0] sel);
        logic [ROM_BANK_W-1:0] r;
        r = '0;
        for (int i = 0; i < ROM_SEL_VALUES; i++) begin
            if (sel == ROM_SEL_W'(i)) begin
                r = ROM_BANK_W'(i % ROM_BANKS);
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/mbc1_if.sv -----
interface mbc1_req_if;
    logic                         valid;
    logic                         ready;
    logic [mbc1_pkg::FUNC_W-1:0]     func;
    logic [mbc1_pkg::ADDR_W-1:0]     addr;
    logic [mbc1_pkg::DATA_W-1:0]     data;
    logic [mbc1_pkg::ROM_ADDR_W-1:0] rom_offset;

    modport source (output valid, func, addr, data, rom_offset, input ready);
    modport sink   (input valid, func, addr, data, rom_offset, output ready);
endinterface

interface mbc1_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [mbc1_pkg::DATA_W-1:0] read_data;
    logic                     invalid;

    modport source (output valid, read_data, invalid, input ready);
    modport sink   (input valid, read_data, invalid, output ready);
endinterface

// ----- hw/rtl/mbc1_rom.sv -----
module mbc1_rom (
    input  logic                          clk,
    input  mbc1_pkg::rom_req_t            req,
    output logic [mbc1_pkg::DATA_W-1:0]   rdata
);
    import mbc1_pkg::*;

    logic [DATA_W-1:0] mem [ROM_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Load one byte or read one byte per cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mbc1_ram.sv -----
module mbc1_ram (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mbc1_pkg::ram_req_t            req,
    output logic [mbc1_pkg::DATA_W-1:0]   rdata,
    output logic                          ready
);
    import mbc1_pkg::*;

    logic [DATA_W-1:0]    mem [RAM_DEPTH];
    logic [DATA_W-1:0]    rdata_reg;
    logic [CLR_CNT_W-1:0] clr_cnt_reg;
    logic [CLR_CNT_W-1:0] clr_cnt_next;
    logic                 clearing;

    // Clear sweep runs until the counter reaches the depth
    assign clearing     = ~clr_cnt_reg[CLR_CNT_W-1];
    assign clr_cnt_next = clearing ? clr_cnt_reg + CLR_CNT_W'(1) : clr_cnt_reg;
    assign ready        = ~clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Write zero while clearing, else serve the request
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_cnt_reg[RAM_ADDR_W-1:0]] <= '0;
        end
        else if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mbc1_bank_controller.sv -----
// A bus read word gives its result in the cycle after acceptance.
// Throughput: one word per cycle while bus_in.ready is high; each word makes at most one ROM or RAM access.
// Writes and ROM loads give no result.
// Reset: bank registers go to ROM bank 1, RAM bank 0, ROM mode; ROM keeps its bytes.
// After reset the RAM is swept to zero with bus_in.ready low.
module mbc1_bank_controller (
    input  logic          clk,
    input  logic          rst_n,
    mbc1_req_if.sink      bus_in,
    mbc1_rsp_if.source    bus_out
);
    import mbc1_pkg::*;

    logic                    accept;
    func_t                   fn;
    logic [2:0]              region;
    logic                    ram_ready;
    rom_req_t                rom_req;
    ram_req_t                ram_req;
    logic [DATA_W-1:0]       rom_rdata;
    logic [DATA_W-1:0]       ram_rdata;
    logic [ROM_BANK_W-1:0]   bank_eff;

    logic [ROM_SEL_W-1:0]    rom_sel_reg, rom_sel_next;
    logic [RAM_SEL_W-1:0]    ram_sel_reg, ram_sel_next;
    logic                    mode_reg, mode_next;
    logic                    out_valid_reg, out_valid_next;
    src_t                    src_reg, src_next;

    assign fn     = func_t'(bus_in.func);
    assign region = bus_in.addr[ADDR_W-1:ADDR_W-3];

    // Take a word when the RAM is swept and the result slot frees up
    assign bus_in.ready = ram_ready && (!out_valid_reg || bus_out.ready);
    assign accept       = bus_in.valid && bus_in.ready;

    assign bank_eff = bank_wrap(rom_sel_reg);

    // Build memory requests
    always_comb
    begin
        rom_req.we    = accept && (fn == FUNC_LOAD);
        rom_req.re    = accept && (fn == FUNC_READ) && !bus_in.addr[ADDR_W-1];
        rom_req.wdata = bus_in.data;
        if (fn == FUNC_LOAD)
        begin
            rom_req.addr = bus_in.rom_offset;
        end
        else if (bus_in.addr[BANK_AW])
        begin
            rom_req.addr = {bank_eff, bus_in.addr[BANK_AW-1:0]};
        end
        else
        begin
            rom_req.addr = {ROM_BANK_W'(0), bus_in.addr[BANK_AW-1:0]};
        end

        ram_req.we    = accept && (fn == FUNC_WRITE) && (region == REGION_EXT_RAM);
        ram_req.re    = accept && (fn == FUNC_READ) && (region == REGION_EXT_RAM);
        ram_req.addr  = {ram_sel_reg, bus_in.addr[RAM_BANK_AW-1:0]};
        ram_req.wdata = bus_in.data;
    end

    // Bank and mode register updates on bus writes
    always_comb
    begin
        rom_sel_next = rom_sel_reg;
        ram_sel_next = ram_sel_reg;
        mode_next    = mode_reg;
        if (accept && (fn == FUNC_WRITE))
        begin
            unique case (region)
                REGION_ROM_LOW:
                begin
                    rom_sel_next = ROM_SEL_W'(bus_in.data & ROM_LOW_MASK);
                end
                REGION_BANK_HI:
                begin
                    if (mode_reg)
                    begin
                        ram_sel_next = bus_in.data[RAM_SEL_W-1:0];
                    end
                    else
                    begin
                        rom_sel_next = {bus_in.data[1:0], rom_sel_reg[4:0]};
                    end
                end
                REGION_MODE:
                begin
                    mode_next = (bus_in.data == DATA_W'(1));
                end
                default:
                begin
                    rom_sel_next = rom_sel_reg;
                end
            endcase
        end
    end

    // Result slot: fill on a read, drop when taken
    always_comb
    begin
        src_next       = src_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = (fn == FUNC_READ);
            if (fn == FUNC_READ)
            begin
                if (!bus_in.addr[ADDR_W-1])
                begin
                    src_next = SRC_ROM;
                end
                else if (region == REGION_EXT_RAM)
                begin
                    src_next = SRC_RAM;
                end
                else
                begin
                    src_next = SRC_INVALID;
                end
            end
        end
        else if (bus_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_sel_reg   <= ROM_SEL_RESET;
            ram_sel_reg   <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            src_reg       <= SRC_INVALID;
        end
        else
        begin
            rom_sel_reg   <= rom_sel_next;
            ram_sel_reg   <= ram_sel_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            src_reg       <= src_next;
        end
    end

    mbc1_rom u_rom (
        .clk   (clk),
        .req   (rom_req),
        .rdata (rom_rdata)
    );

    mbc1_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (ram_rdata),
        .ready (ram_ready)
    );

    // Steer the registered memory word to the output
    always_comb
    begin
        unique case (src_reg)
            SRC_ROM:     bus_out.read_data = rom_rdata;
            SRC_RAM:     bus_out.read_data = ram_rdata;
            default:     bus_out.read_data = '0;
        endcase
    end

    assign bus_out.invalid = (src_reg == SRC_INVALID);
    assign bus_out.valid   = out_valid_reg;

endmodule

// ----- hw/rtl/mbc1_checker.sv -----
module mbc1_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [mbc1_pkg::FUNC_W-1:0]   in_func,
    input logic [mbc1_pkg::ADDR_W-1:0]   in_addr,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mbc1_pkg::DATA_W-1:0]   out_read_data,
    input logic                          out_invalid
);
    import mbc1_pkg::*;

    logic in_acc;
    logic rd_acc;

    assign in_acc = in_valid && in_ready;
    assign rd_acc = in_acc && (in_func == FUNC_READ);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_read_data)
            && $stable(out_invalid))
        else $error("result word changed while stalled");

    // Every accepted read shows a result on the next cycle
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        rd_acc |=> out_valid)
        else $error("accepted read gave no result");

    // Writes and loads give no result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_func != FUNC_READ) && (!out_valid || out_ready) |=> !out_valid)
        else $error("result appeared without a read");

    // Reads of the ROM window are never flagged
    a_rom_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rd_acc && !in_addr[ADDR_W-1] |=> !out_invalid)
        else $error("ROM read flagged invalid");

    // A flagged word carries zero data
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_invalid |-> out_read_data == '0)
        else $error("invalid result with nonzero data");

endmodule

bind mbc1_bank_controller mbc1_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (bus_in.valid),
    .in_ready      (bus_in.ready),
    .in_func       (bus_in.func),
    .in_addr       (bus_in.addr),
    .out_valid     (bus_out.valid),
    .out_ready     (bus_out.ready),
    .out_read_data (bus_out.read_data),
    .out_invalid   (bus_out.invalid)
);
